// ===== sv/hstg_pkg.sv =====
// package: sizes, coefficients, register indexes and sequencer states of the tone generator
package hstg_pkg;

    localparam int MAX_CHANNELS    = 8;
    localparam int PHASE_BITS      = 24;
    localparam int SINE_TABLE_BITS = 10;

    localparam int STEP_W    = 24;
    localparam int SAMPLE_W  = 16;
    localparam int CHAN_W    = 3;
    localparam int COUNT_W   = 4;
    localparam int AMP_W     = 15;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 15;

    localparam int N_W    = $clog2(MAX_CHANNELS + 1);
    localparam int FRAC_W = SINE_TABLE_BITS - 2;
    localparam int MUL_W  = 17;
    localparam int PROD_W = 2 * MUL_W;

    localparam logic [MUL_W-1:0] COEF_A = 17'd102944;
    localparam logic [MUL_W-1:0] COEF_B = 17'd42048;
    localparam logic [MUL_W-1:0] COEF_C = 17'd4640;

    localparam logic [COUNT_W-1:0] RST_CHANNEL_COUNT = 4'd2;
    localparam logic [AMP_W-1:0]   RST_AMPLITUDE     = 15'd6400;
    localparam logic [AMP_W-1:0]   SINE_MAX          = 15'd32767;

    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE     = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ,
        S_C,
        S_B,
        S_A,
        S_AMP,
        S_OUT
    } t_state;

endpackage

// ===== sv/hstg_if.sv =====
// stream interfaces: phase step input and sample output
interface hstg_in_if;
    logic                         valid;
    logic                         ready;
    logic [hstg_pkg::STEP_W-1:0]  phase_step;

    modport source (output valid, output phase_step, input ready);
    modport sink   (input valid, input phase_step, output ready);
endinterface

interface hstg_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [hstg_pkg::SAMPLE_W-1:0] sample;
    logic [hstg_pkg::CHAN_W-1:0]          channel;
    logic                                last;

    modport source (output valid, output sample, output channel, output last, input ready);
    modport sink   (input valid, input sample, input channel, input last, output ready);
endinterface

// ===== sv/harmonic_sine_tone_generator.sv =====
// top level: phase accumulator with harmonic sine evaluation on one shared multiplier
//
//  channel   dir   payload                          transfer
//  i_in      in    phase_step                       valid && ready
//  o_out     out   sample, channel, last            valid && ready
//  cfg       in    i_cfg_index, i_cfg_data          i_cfg_we
//
// for each of the n active channels an item takes five products on the
// shared 17x17 multiplier and one output load, with the sequencer stepping
// through the polynomial. a stalled output holds the sequencer in the
// load state. synchronous reset clears phase, registers to defaults, and the fsm.
module harmonic_sine_tone_generator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [hstg_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [hstg_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    hstg_in_if.sink                             i_in,
    hstg_out_if.source                          o_out
);
    import hstg_pkg::*;

    t_state r_state, n_state;

    logic [COUNT_W-1:0]    r_channel_count;
    logic [AMP_W-1:0]      r_amplitude;
    logic [PHASE_BITS-1:0] r_phase;
    logic [PHASE_BITS-1:0] r_angle;
    logic [N_W-1:0]        r_n;
    logic [N_W-1:0]        r_k;
    logic [MUL_W-1:0]      r_z2;
    logic [PROD_W-1:0]     r_prod;

    logic                        r_out_valid;
    logic signed [SAMPLE_W-1:0]  r_sample;
    logic [CHAN_W-1:0]           r_chan;
    logic                        r_last;

    logic [PHASE_BITS-1:0] phase_next;
    logic [N_W-1:0]        n_active;
    logic [31:0]           turn32;
    logic [SINE_TABLE_BITS-1:0] idx;
    logic [FRAC_W-1:0]     frac;
    logic [MUL_W-1:0]      z_raw;
    logic [MUL_W-1:0]      z;
    logic                  neg;
    logic [SAMPLE_W-1:0]   v_raw;
    logic [AMP_W-1:0]      v_sat;
    logic [AMP_W-1:0]      mag;
    logic [MUL_W-1:0]      mul_a;
    logic [MUL_W-1:0]      mul_b;
    logic                  in_ready;
    logic                  in_xfer;
    logic                  out_free;
    logic                  is_last;

    // angle to quadrant and q16 fraction
    assign turn32 = {r_angle, {(32 - PHASE_BITS){1'b0}}};
    assign idx    = turn32[31 -: SINE_TABLE_BITS];
    assign frac   = idx[FRAC_W-1:0];
    assign z_raw  = MUL_W'(frac) << (16 - FRAC_W);
    assign z      = idx[SINE_TABLE_BITS-2] ? (17'd65536 - z_raw) : z_raw;
    assign neg    = idx[SINE_TABLE_BITS-1];

    assign v_raw = r_prod[32:17];
    assign v_sat = (v_raw > SAMPLE_W'(SINE_MAX)) ? SINE_MAX : v_raw[AMP_W-1:0];
    assign mag   = r_prod[AMP_W+14:15];

    assign phase_next = r_phase + PHASE_BITS'(i_in.phase_step);
    assign n_active   = (32'(r_channel_count) > MAX_CHANNELS) ? N_W'(MAX_CHANNELS)
                                                               : N_W'(r_channel_count);
    assign in_xfer  = i_in.valid && in_ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign is_last  = (r_k + N_W'(1)) == r_n;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer && n_active != '0) begin
                    n_state = S_SQ;
                end
            end
            S_SQ:  n_state = S_C;
            S_C:   n_state = S_B;
            S_B:   n_state = S_A;
            S_A:   n_state = S_AMP;
            S_AMP: n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_state = is_last ? S_IDLE : S_SQ;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // multiplier operand select and handshake
    always_comb begin
        mul_a    = '0;
        mul_b    = '0;
        in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: in_ready = 1'b1;
            S_SQ: begin
                mul_a = z;
                mul_b = z;
            end
            S_C: begin
                mul_a = COEF_C;
                mul_b = r_prod[32:16];
            end
            S_B: begin
                mul_a = COEF_B - MUL_W'(r_prod[31:16]);
                mul_b = r_z2;
            end
            S_A: begin
                mul_a = COEF_A - r_prod[32:16];
                mul_b = z;
            end
            S_AMP: begin
                mul_a = MUL_W'(r_amplitude);
                mul_b = MUL_W'(v_sat);
            end
            S_OUT: begin
                mul_a = '0;
                mul_b = '0;
            end
            default: in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_channel_count <= RST_CHANNEL_COUNT;
            r_amplitude     <= RST_AMPLITUDE;
            r_phase         <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[COUNT_W-1:0];
                    CFG_AMPLITUDE:     r_amplitude     <= i_cfg_data[AMP_W-1:0];
                    default:           r_amplitude     <= r_amplitude;
                endcase
            end
            if (in_xfer) begin
                r_phase <= phase_next;
            end
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        // scaled sample is held while the output stalls
        if (r_state != S_OUT) begin
            r_prod <= mul_a * mul_b;
        end
        if (r_state == S_C) begin
            r_z2 <= r_prod[32:16];
        end
        if (in_xfer) begin
            r_angle <= phase_next;
            r_n     <= n_active;
            r_k     <= '0;
        end
        if (r_state == S_OUT && out_free) begin
            r_sample <= neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
            r_chan   <= CHAN_W'(r_k);
            r_last   <= is_last;
            r_angle  <= r_angle + r_phase;
            r_k      <= r_k + N_W'(1);
        end
    end

    assign i_in.ready    = in_ready;
    assign o_out.valid   = r_out_valid;
    assign o_out.sample  = r_sample;
    assign o_out.channel = r_chan;
    assign o_out.last    = r_last;

endmodule
